>>> src/lsre_pkg.sv
// Shared opcodes, ALU codes and the decoded instruction record.
package lsre_pkg;

  // Instruction opcodes
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_SLL  = 4'd6;
  localparam logic [3:0] OP_SRL  = 4'd7;
  localparam logic [3:0] OP_ADDI = 4'd8;
  localparam logic [3:0] OP_LW   = 4'd9;
  localparam logic [3:0] OP_SW   = 4'd10;
  localparam logic [3:0] OP_BEQ  = 4'd11;
  localparam logic [3:0] OP_J    = 4'd12;

  // ALU functions
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_MUL = 3'd2;
  localparam logic [2:0] ALU_AND = 3'd3;
  localparam logic [2:0] ALU_OR  = 3'd4;
  localparam logic [2:0] ALU_SLL = 3'd5;
  localparam logic [2:0] ALU_SRL = 3'd6;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  alu_op;
    logic        use_imm;
    logic        writes_alu;
    logic        is_load;
    logic        is_store;
    logic        is_beq;
    logic        is_jump;
    logic [4:0]  dest;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [9:0]  target;
  } decoded_t;

endpackage

>>> src/lsre_in_if.sv
// Instruction request channel.
interface lsre_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [4:0]  rs_index;
  logic [4:0]  rt_index;
  logic [4:0]  rd_index;
  logic [15:0] immediate;
  logic [9:0]  jump_target;

  modport source (
    output valid, opcode, rs_index, rt_index, rd_index, immediate, jump_target,
    input  ready
  );
  modport sink (
    input  valid, opcode, rs_index, rt_index, rd_index, immediate, jump_target,
    output ready
  );
endinterface

>>> src/lsre_out_if.sv
// Result request channel.
interface lsre_out_if;
  logic               valid;
  logic               ready;
  logic               reg_write;
  logic [4:0]         dest_index;
  logic signed [31:0] write_value;
  logic               branch_taken;
  logic [9:0]         branch_target;
  logic               mem_error;

  modport source (
    output valid, reg_write, dest_index, write_value, branch_taken, branch_target,
           mem_error,
    input  ready
  );
  modport sink (
    input  valid, reg_write, dest_index, write_value, branch_taken, branch_target,
           mem_error,
    output ready
  );
endinterface

>>> src/lsre_front.sv
// Front end: accepts instruction requests and decodes them into control records.
module lsre_front (
  lsre_in_if.sink            instr,
  input  logic               busy,
  input  logic               push_ready,
  output logic               push_valid,
  output lsre_pkg::decoded_t push_data
);
  import lsre_pkg::*;

  decoded_t dec;

  always_comb begin
    dec            = '0;
    dec.rs         = instr.rs_index;
    dec.rt         = instr.rt_index;
    dec.imm        = instr.immediate;
    dec.target     = instr.jump_target;
    case (instr.opcode)
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_SLL, OP_SRL: begin
        dec.writes_alu = 1'b1;
        dec.dest       = instr.rd_index;
        case (instr.opcode)
          OP_SUB:  dec.alu_op = ALU_SUB;
          OP_MUL:  dec.alu_op = ALU_MUL;
          OP_AND:  dec.alu_op = ALU_AND;
          OP_OR:   dec.alu_op = ALU_OR;
          OP_SLL:  dec.alu_op = ALU_SLL;
          OP_SRL:  dec.alu_op = ALU_SRL;
          default: dec.alu_op = ALU_ADD;
        endcase
      end
      OP_ADDI: begin
        dec.writes_alu = 1'b1;
        dec.use_imm    = 1'b1;
        dec.alu_op     = ALU_ADD;
        dec.dest       = instr.rt_index;
      end
      OP_LW: begin
        dec.is_load = 1'b1;
        dec.dest    = instr.rt_index;
      end
      OP_SW:   dec.is_store = 1'b1;
      OP_BEQ:  dec.is_beq   = 1'b1;
      OP_J:    dec.is_jump  = 1'b1;
      default: dec.alu_op   = ALU_ADD;  // NOP and unused codes
    endcase
  end

  assign instr.ready = push_ready && !busy;
  assign push_valid  = instr.valid && !busy;
  assign push_data   = dec;

endmodule

>>> src/lsre_queue.sv
// Short FIFO of decoded instructions between front and back.
module lsre_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  lsre_pkg::decoded_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output lsre_pkg::decoded_t pop_data
);
  import lsre_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  decoded_t        entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> src/lsre_back.sv
// Back end: register file, ALU, data memory, writeback and result register.
module lsre_back #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  lsre_pkg::decoded_t q_data,
  output logic               busy,
  lsre_out_if.source         result
);
  import lsre_pkg::*;

  localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;

  logic adv;

  // register file: two registered read ports, one write port, valid bits
  logic [31:0] rf_mem [32];
  logic [31:0] rf_ok;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic        rf_a_ok;
  logic        rf_b_ok;

  // data memory and clear sweep
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] dmem_q;
  logic        clr_active;
  logic [AW:0] clr_idx;

  // execute stage
  logic        x_valid;
  decoded_t    x_ctl;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] simm;
  logic [31:0] op2;
  logic [31:0] alu_val;
  logic [31:0] addr;
  logic        addr_ok;
  logic [AW-1:0] dmem_idx;
  logic        x_taken;

  // memory stage
  logic        m_valid;
  logic [4:0]  m_dest;
  logic [31:0] m_alu;
  logic        m_writes_alu;
  logic        m_load;
  logic        m_memop;
  logic        m_ok;
  logic        m_taken;
  logic [9:0]  m_target;
  logic [31:0] m_value;
  logic        m_wr;

  // last writeback, for the read-during-write case
  logic        w_valid;
  logic [4:0]  w_dest;
  logic [31:0] w_value;

  // result register
  logic               o_valid;
  logic               o_reg_write;
  logic [4:0]         o_dest;
  logic signed [31:0] o_value;
  logic               o_taken;
  logic [9:0]         o_target;
  logic               o_error;

  assign adv     = !o_valid || result.ready;
  assign q_ready = adv;
  assign busy    = clr_active;

  // register file read and write
  always_ff @(posedge clk) begin
    if (adv) begin
      rf_a <= rf_mem[q_data.rs];
      rf_b <= rf_mem[q_data.rt];
    end
    if (adv && m_wr) rf_mem[m_dest] <= m_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok   <= '0;
      rf_a_ok <= 1'b0;
      rf_b_ok <= 1'b0;
    end else if (adv) begin
      rf_a_ok <= rf_ok[q_data.rs];
      rf_b_ok <= rf_ok[q_data.rt];
      if (m_wr) rf_ok[m_dest] <= 1'b1;
    end
  end

  // operand bypass: older instruction in M first, then last writeback
  always_comb begin
    op_a = rf_a_ok ? rf_a : '0;
    if (m_wr && m_dest == x_ctl.rs)            op_a = m_value;
    else if (w_valid && w_dest == x_ctl.rs)    op_a = w_value;
    op_b = rf_b_ok ? rf_b : '0;
    if (m_wr && m_dest == x_ctl.rt)            op_b = m_value;
    else if (w_valid && w_dest == x_ctl.rt)    op_b = w_value;
  end

  assign simm = {{16{x_ctl.imm[15]}}, x_ctl.imm};
  assign op2  = x_ctl.use_imm ? simm : op_b;

  always_comb begin
    case (x_ctl.alu_op)
      ALU_ADD: alu_val = op_a + op2;
      ALU_SUB: alu_val = op_a - op_b;
      ALU_MUL: alu_val = op_a * op_b;
      ALU_AND: alu_val = op_a & op_b;
      ALU_OR:  alu_val = op_a | op_b;
      ALU_SLL: alu_val = op_b << x_ctl.imm[4:0];
      ALU_SRL: alu_val = op_b >> x_ctl.imm[4:0];
      default: alu_val = '0;
    endcase
  end

  assign addr     = op_a + simm;
  assign addr_ok  = !addr[31] && ({2'b00, addr[31:2]} < 32'(DMEM_WORDS));
  assign dmem_idx = addr[AW+1:2];
  assign x_taken  = x_ctl.is_jump || (x_ctl.is_beq && op_a == op_b);

  // data memory: clear sweep after reset, stores and loads otherwise
  always_ff @(posedge clk) begin
    if (clr_active) begin
      dmem[clr_idx[AW-1:0]] <= '0;
    end else if (adv && x_valid && x_ctl.is_store && addr_ok) begin
      dmem[dmem_idx] <= op_b;
    end
    if (adv && x_valid && x_ctl.is_load && addr_ok) dmem_q <= dmem[dmem_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == (AW+1)'(DMEM_WORDS - 1)) clr_active <= 1'b0;
      else                                    clr_idx    <= clr_idx + 1'b1;
    end
  end

  // stage advance
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      m_valid <= 1'b0;
      w_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      x_valid <= q_valid;
      m_valid <= x_valid;
      w_valid <= m_wr;
      o_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_ctl        <= q_data;
      m_dest       <= x_ctl.dest;
      m_alu        <= x_ctl.writes_alu ? alu_val : '0;
      m_writes_alu <= x_ctl.writes_alu;
      m_load       <= x_ctl.is_load;
      m_memop      <= x_ctl.is_load || x_ctl.is_store;
      m_ok         <= addr_ok;
      m_taken      <= x_taken;
      m_target     <= x_taken ? x_ctl.target : '0;
      w_dest       <= m_dest;
      w_value      <= m_value;
      o_reg_write  <= m_wr;
      o_dest       <= m_dest;
      o_value      <= m_value;
      o_taken      <= m_taken;
      o_target     <= m_target;
      o_error      <= m_memop && !m_ok;
    end
  end

  assign m_value = m_load ? (m_ok ? dmem_q : '0) : m_alu;
  assign m_wr    = m_valid && (m_writes_alu || (m_load && m_ok)) && m_dest != '0;

  assign result.valid         = o_valid;
  assign result.reg_write     = o_reg_write;
  assign result.dest_index    = o_dest;
  assign result.write_value   = o_value;
  assign result.branch_taken  = o_taken;
  assign result.branch_target = o_target;
  assign result.mem_error     = o_error;

endmodule

>>> src/load_store_risc_execute_core_top.sv
// Top level of the load/store RISC execute core.
// Path: an accepted request passes in order through the queue head, execute with register
//   bypass, memory/writeback and the result register before its result shows.
// Throughput: one instruction per cycle while not stalled; under result stall the result
//   register holds while the 2-entry queue takes requests until full. Reset: register file
//   valid bits clear at once; data memory is swept to zero, with instr.ready low meanwhile.
module load_store_risc_execute_core_top #(
  parameter int DMEM_WORDS = 1024  // data memory depth in 32-bit words
) (
  input logic        clk,
  input logic        rst,
  lsre_in_if.sink    instr,
  lsre_out_if.source result
);
  import lsre_pkg::*;

  // front to queue
  logic     push_valid;
  logic     push_ready;
  decoded_t push_data;

  // queue to back
  logic     pop_valid;
  logic     pop_ready;
  decoded_t pop_data;

  // back holds the front off during the memory clear sweep
  logic     busy;

  // decode: classifies each request into a control record
  lsre_front u_front (
    .instr      (instr),
    .busy       (busy),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // decouples request acceptance from back-end stalls
  lsre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // execute: register read, ALU/branch, data memory, writeback, result
  lsre_back #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .busy    (busy),
    .result  (result)
  );

endmodule
